// ===== design/smap_pkg.sv =====
// Package for the STUN mapped-address parser: protocol constants, parse phase
// codes, result status codes and the result record. No dependencies.
package smap_pkg;

  // Width of the saturating byte position counter by default.
  localparam int unsigned PositionBitsDefault = 16;

  // STUN protocol constants.
  localparam logic [31:0] COOKIE_WORD     = 32'h2112_A442;
  localparam int unsigned HEADER_BYTES    = 20;
  localparam logic [15:0] TYPE_RESPONSE   = 16'h0101;
  localparam logic [15:0] ATTR_XOR_MAPPED = 16'h0020;
  localparam logic [3:0]  ADDR_VALUE_BYTES = 4'd8;

  // Parse phase codes.
  localparam logic [2:0] PH_HEADER   = 3'd0;
  localparam logic [2:0] PH_ATTR_HDR = 3'd1;
  localparam logic [2:0] PH_SKIP     = 3'd2;
  localparam logic [2:0] PH_VALUE    = 3'd3;
  localparam logic [2:0] PH_DONE     = 3'd4;

  // Result status codes.
  typedef enum logic [2:0] {
    STATUS_OK         = 3'd0,
    STATUS_TOO_SHORT  = 3'd1,
    STATUS_BAD_COOKIE = 3'd2,
    STATUS_BAD_TYPE   = 3'd3,
    STATUS_NO_ADDRESS = 3'd4,
    STATUS_TRUNCATED  = 3'd5
  } status_e;

  // One result per packet.
  typedef struct packed {
    logic        found;
    status_e     status;
    logic [31:0] mapped_ip;
    logic [15:0] mapped_port;
  } result_t;

  // Byte of the magic cookie expected at header offset 4 + idx.
  function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = COOKIE_WORD[31:24];
      2'd1:    b = COOKIE_WORD[23:16];
      2'd2:    b = COOKIE_WORD[15:8];
      default: b = COOKIE_WORD[7:0];
    endcase
    return b;
  endfunction

endpackage

// ===== design/smap_if.sv =====
// Valid/ready channel interfaces for the STUN mapped-address parser:
// the byte input channel and the result channel. No dependencies.
interface smap_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       last_byte;

  modport source (output valid, output rx_byte, output last_byte, input ready);
  modport sink (input valid, input rx_byte, input last_byte, output ready);
endinterface

interface smap_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [2:0]  status;
  logic [31:0] mapped_ip;
  logic [15:0] mapped_port;

  modport source (output valid, output found, output status, output mapped_ip,
                  output mapped_port, input ready);
  modport sink (input valid, input found, input status, input mapped_ip,
                input mapped_port, output ready);
endinterface

// ===== design/smap_parser.sv =====
// Per-byte parse state of the STUN mapped-address parser and its next-state
// logic; gives the packet result for the byte being consumed. Uses smap_pkg.
module smap_parser
  import smap_pkg::*;
#(
  parameter int unsigned PositionBits = PositionBitsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] rx_byte_i,
  input  logic       last_byte_i,
  output result_t    result_o
);

  logic [PositionBits-1:0] pos_q, pos_d;
  logic [2:0]  phase_q, phase_d;
  logic        cookie_bad_q, cookie_bad_d;
  logic        type_bad_q, type_bad_d;
  logic [1:0]  ahi_q, ahi_d;
  logic [15:0] atype_q, atype_d;
  logic [15:0] alen_q, alen_d;
  logic [16:0] skip_q, skip_d;
  logic [3:0]  vidx_q, vidx_d;
  logic [15:0] xport_q, xport_d;
  logic [31:0] xip_q, xip_d;
  logic        done_q, done_d;
  logic [1:0]  pad;

  // Next state for one consumed byte.
  always_comb begin
    pos_d        = pos_q;
    phase_d      = phase_q;
    cookie_bad_d = cookie_bad_q;
    type_bad_d   = type_bad_q;
    ahi_d        = ahi_q;
    atype_d      = atype_q;
    alen_d       = alen_q;
    skip_d       = skip_q;
    vidx_d       = vidx_q;
    xport_d      = xport_q;
    xip_d        = xip_q;
    done_d       = done_q;
    pad          = 2'd0;
    case (phase_q)
      PH_HEADER: begin
        if (pos_q < PositionBits'(2) && rx_byte_i != TYPE_RESPONSE[7:0]) begin
          type_bad_d = 1'b1;
        end
        if (pos_q >= PositionBits'(4) && pos_q < PositionBits'(8) &&
            rx_byte_i != cookie_byte(pos_q[1:0])) begin
          cookie_bad_d = 1'b1;
        end
        if (pos_q == PositionBits'(HEADER_BYTES - 1)) begin
          phase_d = PH_ATTR_HDR;
        end
      end
      PH_ATTR_HDR: begin
        case (ahi_q)
          2'd0:    atype_d = {rx_byte_i, 8'h00};
          2'd1:    atype_d = atype_q | {8'h00, rx_byte_i};
          2'd2:    alen_d  = {rx_byte_i, 8'h00};
          default: alen_d  = alen_q | {8'h00, rx_byte_i};
        endcase
        // The attribute header is complete on its fourth byte.
        if (ahi_q == 2'd3) begin
          if (atype_q == ATTR_XOR_MAPPED) begin
            if (alen_d < {12'd0, ADDR_VALUE_BYTES}) begin
              // Loading the cookie makes the decoded address zero.
              xport_d = COOKIE_WORD[31:16];
              xip_d   = COOKIE_WORD;
              done_d  = 1'b1;
              phase_d = PH_DONE;
            end else begin
              vidx_d  = 4'd0;
              phase_d = PH_VALUE;
            end
          end else begin
            pad     = 2'd0 - alen_d[1:0];
            skip_d  = {1'b0, alen_d} + {15'd0, pad};
            phase_d = (skip_d == 17'd0) ? PH_ATTR_HDR : PH_SKIP;
          end
        end
        ahi_d = ahi_q + 2'd1;
      end
      PH_SKIP: begin
        if (skip_q != 17'd0) begin
          skip_d = skip_q - 17'd1;
        end
        if (skip_d == 17'd0) begin
          phase_d = PH_ATTR_HDR;
        end
      end
      PH_VALUE: begin
        if (vidx_q == 4'd2) begin
          xport_d = {rx_byte_i, 8'h00};
        end else if (vidx_q == 4'd3) begin
          xport_d = xport_q | {8'h00, rx_byte_i};
        end else if (vidx_q >= 4'd4 && vidx_q < ADDR_VALUE_BYTES) begin
          xip_d = {xip_q[23:0], rx_byte_i};
        end
        vidx_d = vidx_q + 4'd1;
        if (vidx_d >= ADDR_VALUE_BYTES) begin
          done_d  = 1'b1;
          phase_d = PH_DONE;
        end
      end
      default: begin
      end
    endcase
    if (pos_q != '1) begin
      pos_d = pos_q + PositionBits'(1);
    end
  end

  // Packet result, taken from the state after this byte.
  always_comb begin
    result_o = '{found: 1'b0, status: STATUS_NO_ADDRESS, mapped_ip: 32'd0,
                 mapped_port: 16'd0};
    if (phase_d == PH_HEADER) begin
      result_o.status = STATUS_TOO_SHORT;
    end else if (cookie_bad_d) begin
      result_o.status = STATUS_BAD_COOKIE;
    end else if (type_bad_d) begin
      result_o.status = STATUS_BAD_TYPE;
    end else if (done_d) begin
      result_o.found       = 1'b1;
      result_o.status      = STATUS_OK;
      result_o.mapped_ip   = xip_d ^ COOKIE_WORD;
      result_o.mapped_port = xport_d ^ COOKIE_WORD[31:16];
    end else if (phase_d == PH_VALUE) begin
      result_o.status = STATUS_TRUNCATED;
    end
  end

  // State registers; the last byte of a packet returns all state to reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      phase_q      <= PH_HEADER;
      cookie_bad_q <= 1'b0;
      type_bad_q   <= 1'b0;
      ahi_q        <= 2'd0;
      atype_q      <= 16'd0;
      alen_q       <= 16'd0;
      skip_q       <= 17'd0;
      vidx_q       <= 4'd0;
      xport_q      <= 16'd0;
      xip_q        <= 32'd0;
      done_q       <= 1'b0;
    end else if (step_i) begin
      if (last_byte_i) begin
        pos_q        <= '0;
        phase_q      <= PH_HEADER;
        cookie_bad_q <= 1'b0;
        type_bad_q   <= 1'b0;
        ahi_q        <= 2'd0;
        atype_q      <= 16'd0;
        alen_q       <= 16'd0;
        skip_q       <= 17'd0;
        vidx_q       <= 4'd0;
        xport_q      <= 16'd0;
        xip_q        <= 32'd0;
        done_q       <= 1'b0;
      end else begin
        pos_q        <= pos_d;
        phase_q      <= phase_d;
        cookie_bad_q <= cookie_bad_d;
        type_bad_q   <= type_bad_d;
        ahi_q        <= ahi_d;
        atype_q      <= atype_d;
        alen_q       <= alen_d;
        skip_q       <= skip_d;
        vidx_q       <= vidx_d;
        xport_q      <= xport_d;
        xip_q        <= xip_d;
        done_q       <= done_d;
      end
    end
  end

  // A consumed last byte leaves the parser at the start of a new packet.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_byte_i |=> phase_q == PH_HEADER && pos_q == '0)
    else $error("parser state not cleared after the last byte");

  // A decoded address always parks the parser in the done phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> phase_q == PH_DONE)
    else $error("address decoded outside the done phase");

  // The skip count is only nonzero while skipping.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skip_q != 17'd0 |-> phase_q == PH_SKIP)
    else $error("skip count left over outside the skip phase");

endmodule

// ===== design/stun_mapped_address_parser_top.sv =====
// Top level of the STUN binding-response XOR-MAPPED-ADDRESS parser: input
// register, parse state (smap_parser) and result register. Uses smap_pkg, smap_if.
//
//   channel | dir | payload                                  | transactions
//   in_i    | in  | rx_byte, last_byte                       | one per packet byte
//   out_o   | out | found, status, mapped_ip, mapped_port    | one per packet
//
// One byte per cycle is sustained while no closing byte waits for the result slot;
// a registered byte is parsed by the next-state logic of the parse state.
// A result is loaded into the result register when its last byte leaves the input register.
// Reset (rst_ni low, asynchronous) empties both registers and clears the parse state.
// A stalled result holds the next packet's last byte in the input register, which then blocks further bytes.
module stun_mapped_address_parser_top
  import smap_pkg::*;
#(
  parameter int unsigned PositionBits = PositionBitsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  smap_in_if.sink   in_i,
  smap_out_if.source out_o
);

  logic       in_vld_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       out_vld_q;
  result_t    res_q;
  result_t    res_d;
  logic       out_free;
  logic       proceed;

  // A registered byte moves on unless it closes a packet and the result slot is busy.
  assign out_free   = !out_vld_q || out_o.ready;
  assign proceed    = in_vld_q && (!last_q || out_free);
  assign in_i.ready = !in_vld_q || proceed;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      byte_q <= in_i.rx_byte;
      last_q <= in_i.last_byte;
    end
  end

  smap_parser #(
    .PositionBits(PositionBits)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (proceed),
    .rx_byte_i   (byte_q),
    .last_byte_i (last_q),
    .result_o    (res_d)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (proceed && last_q) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proceed && last_q) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.found       = res_q.found;
  assign out_o.status      = res_q.status;
  assign out_o.mapped_ip   = res_q.mapped_ip;
  assign out_o.mapped_port = res_q.mapped_port;

  // A new result is loaded only by a consumed last byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(in_vld_q && last_q))
    else $error("result raised without a closing byte");

  // A found address always carries the ok status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.found |-> res_q.status == STATUS_OK)
    else $error("found result with a failure status");

  // Without an address, the address fields are zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !res_q.found |-> res_q.mapped_ip == 32'd0 && res_q.mapped_port == 16'd0)
    else $error("address fields set on a failed packet");

endmodule

// ===== tb/sv/stun_mapped_address_parser_top_test.sv =====
// Self-checking testbench for stun_mapped_address_parser_top: feeds STUN packets
// byte by byte and checks each result against its table row or a cycle-free predictor.
// Depends on smap_pkg, smap_in_if / smap_out_if and the parser top level.
module stun_mapped_address_parser_top_test
  import smap_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PosBits = PositionBitsDefault;
  localparam int NoAttr = -1;
  localparam int NumRows = 21;
  localparam int IdleLimit = 3000;
  localparam int RandomBytes = 470;
  localparam int RandomPackets = 10;
  localparam int HoldCycles = 300;

  // Results that can be read straight off the header and attribute layout.
  localparam result_t R_SHORT  = '{1'b0, STATUS_TOO_SHORT, 32'd0, 16'd0};
  localparam result_t R_COOKIE = '{1'b0, STATUS_BAD_COOKIE, 32'd0, 16'd0};
  localparam result_t R_TYPE   = '{1'b0, STATUS_BAD_TYPE, 32'd0, 16'd0};
  localparam result_t R_NOADDR = '{1'b0, STATUS_NO_ADDRESS, 32'd0, 16'd0};
  localparam result_t R_TRUNC  = '{1'b0, STATUS_TRUNCATED, 32'd0, 16'd0};
  localparam result_t R_ZERO   = '{1'b1, STATUS_OK, 32'd0, 16'd0};
  localparam result_t R_ONES   = '{1'b1, STATUS_OK, 32'hFFFF_FFFF, 16'hFFFF};

  // One directed packet: header words, an optional skipped attribute, an optional
  // address attribute, trailing bytes and an optional cut length.
  typedef struct packed {
    logic [15:0] msg_code;
    logic [31:0] cookie;
    int          skip_len;
    logic [15:0] skip_type;
    int          addr_len;
    logic [15:0] port;
    logic [31:0] ip;
    int          tail;
    int          cut;
    logic        typed;
    result_t     res;
  } packet_row_t;

  // Per-packet note of whether the expected result was typed into the table.
  typedef struct packed {
    logic    typed;
    result_t res;
  } row_check_t;

  logic clk_i;
  logic rst_ni;

  smap_in_if  byte_ch ();
  smap_out_if result_ch ();

  stun_mapped_address_parser_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_ch),
    .out_o  (result_ch)
  );

  // Predictor state of the parser.
  logic [PosBits-1:0] pos;
  logic [2:0]         phase;
  logic               cookie_bad;
  logic               type_bad;
  logic [1:0]         hdr_idx;
  logic [15:0]        cur_code;
  logic [15:0]        cur_size;
  logic [16:0]        skip_left;
  logic [3:0]         val_idx;
  logic [15:0]        xor_port;
  logic [31:0]        xor_ip;
  logic               addr_done;

  result_t     expected_results [$];
  row_check_t  row_results [$];
  logic [7:0]  pkt_bytes [$];
  packet_row_t packet_rows [NumRows];

  int  errors;
  int  pkts_sent;
  int  results_done;
  int  bytes_sent;
  int  idle_cycles;
  bit  tx_calm;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string msg);
    errors++;
    $display("mismatch: %s", msg);
  endtask

  // Returns the predictor to its state after reset.
  function automatic void clear_parser();
    pos        = '0;
    phase      = PH_HEADER;
    cookie_bad = 1'b0;
    type_bad   = 1'b0;
    hdr_idx    = 2'd0;
    cur_code   = 16'd0;
    cur_size   = 16'd0;
    skip_left  = 17'd0;
    val_idx    = 4'd0;
    xor_port   = 16'd0;
    xor_ip     = 32'd0;
    addr_done  = 1'b0;
  endfunction

  // Advances the predictor by one byte; returns 1 with the packet result on the
  // last byte.
  function automatic bit advance_parser(input logic [7:0] b, input logic last,
                                        output result_t res);
    logic [1:0] pad;
    case (phase)
      PH_HEADER: begin
        if (pos < 2 && b != 8'h01) type_bad = 1'b1;
        if (pos >= 4 && pos < 8 && b != COOKIE_WORD[8*(7-pos) +: 8]) cookie_bad = 1'b1;
        if (pos == HEADER_BYTES - 1) phase = PH_ATTR_HDR;
      end
      PH_ATTR_HDR: begin
        case (hdr_idx)
          2'd0:    cur_code = {b, 8'h00};
          2'd1:    cur_code = cur_code | {8'h00, b};
          2'd2:    cur_size = {b, 8'h00};
          default: cur_size = cur_size | {8'h00, b};
        endcase
        // A complete attribute header selects the address value or a skip.
        if (hdr_idx == 2'd3) begin
          if (cur_code == ATTR_XOR_MAPPED) begin
            if (cur_size < 16'd8) begin
              xor_port  = COOKIE_WORD[31:16];
              xor_ip    = COOKIE_WORD;
              addr_done = 1'b1;
              phase     = PH_DONE;
            end else begin
              val_idx = 4'd0;
              phase   = PH_VALUE;
            end
          end else begin
            pad       = 2'd0 - cur_size[1:0];
            skip_left = {1'b0, cur_size} + {15'd0, pad};
            phase     = (skip_left == 17'd0) ? PH_ATTR_HDR : PH_SKIP;
          end
        end
        hdr_idx = hdr_idx + 2'd1;
      end
      PH_SKIP: begin
        if (skip_left > 0) skip_left = skip_left - 17'd1;
        if (skip_left == 0) phase = PH_ATTR_HDR;
      end
      PH_VALUE: begin
        if (val_idx == 4'd2) xor_port = {b, 8'h00};
        else if (val_idx == 4'd3) xor_port = xor_port | {8'h00, b};
        else if (val_idx >= 4'd4 && val_idx < 4'd8) xor_ip = {xor_ip[23:0], b};
        val_idx = val_idx + 4'd1;
        if (val_idx >= 4'd8) begin
          addr_done = 1'b1;
          phase     = PH_DONE;
        end
      end
      default: begin
      end
    endcase

    if (pos != {PosBits{1'b1}}) pos = pos + 1'b1;
    if (!last) return 1'b0;

    // Status priority: short header, cookie, type, then the attribute walk.
    res = '{1'b0, STATUS_NO_ADDRESS, 32'd0, 16'd0};
    if (phase == PH_HEADER) res.status = STATUS_TOO_SHORT;
    else if (cookie_bad) res.status = STATUS_BAD_COOKIE;
    else if (type_bad) res.status = STATUS_BAD_TYPE;
    else if (addr_done) begin
      res.found       = 1'b1;
      res.status      = STATUS_OK;
      res.mapped_ip   = xor_ip ^ COOKIE_WORD;
      res.mapped_port = xor_port ^ COOKIE_WORD[31:16];
    end else if (phase == PH_VALUE) res.status = STATUS_TRUNCATED;
    clear_parser();
    return 1'b1;
  endfunction

  // Packet assembly helpers.
  task automatic push16(input logic [15:0] v);
    pkt_bytes.push_back(v[15:8]);
    pkt_bytes.push_back(v[7:0]);
  endtask

  task automatic push32(input logic [31:0] v);
    push16(v[31:16]);
    push16(v[15:0]);
  endtask

  task automatic add_noise(input int n);
    repeat (n) pkt_bytes.push_back(8'($urandom));
  endtask

  // Header with random message length and transaction id.
  task automatic start_packet(input logic [15:0] msg_code, input logic [31:0] cookie);
    pkt_bytes.delete();
    push16(msg_code);
    push16(16'($urandom));
    push32(cookie);
    add_noise(12);
  endtask

  // Attribute whose value is skipped, padded to a multiple of four bytes.
  task automatic add_skip(input logic [15:0] attr, input int len);
    push16(attr);
    push16(16'(len));
    add_noise(len + ((4 - len % 4) % 4));
  endtask

  // XOR-MAPPED-ADDRESS attribute with an IPv4 value when it is long enough.
  task automatic add_address(input int len, input logic [15:0] port, input logic [31:0] ip);
    push16(ATTR_XOR_MAPPED);
    push16(16'(len));
    if (len >= 8) begin
      pkt_bytes.push_back(8'($urandom));
      pkt_bytes.push_back(8'h01);
      push16(port ^ COOKIE_WORD[31:16]);
      push32(ip ^ COOKIE_WORD);
      add_noise(len - 8 + ((4 - len % 4) % 4));
    end else begin
      add_noise(len + ((4 - len % 4) % 4));
    end
  endtask

  // Cuts or pads the packet to an exact length; zero keeps it as built.
  task automatic cut_packet(input int n);
    if (n > 0) begin
      while (pkt_bytes.size() > n) void'(pkt_bytes.pop_back());
      while (pkt_bytes.size() < n) pkt_bytes.push_back(8'($urandom));
    end
  endtask

  // Offers one byte, with random idle cycles ahead of it, until it is accepted.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!tx_calm && $urandom_range(99) < 18) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.rx_byte   <= b;
    byte_ch.last_byte <= last;
    @(posedge clk_i);
    while (!byte_ch.ready) @(posedge clk_i);
    bytes_sent++;
  endtask

  // Sends the assembled packet and notes how its result is to be checked.
  task automatic send_packet(input logic typed, input result_t res);
    row_results.push_back('{typed, res});
    foreach (pkt_bytes[i]) send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
    pkts_sent++;
  endtask

  // Stimulus: reset, directed table, random packets, drain and verdict.
  initial begin : stimulus
    packet_row_t row;
    int          kind;
    int          rand_pkts;
    int          rand_bytes;
    logic [15:0] msg_code;
    logic [31:0] cookie;
    logic [15:0] attr;

    errors       = 0;
    pkts_sent    = 0;
    results_done = 0;
    bytes_sent   = 0;
    tx_calm      = 1'b0;
    rand_pkts    = 0;
    rand_bytes   = 0;
    clear_parser();
    rst_ni            <= 1'b0;
    byte_ch.valid     <= 1'b0;
    byte_ch.rx_byte   <= 8'd0;
    byte_ch.last_byte <= 1'b0;

    // type, cookie, skip len/type, addr len, port, ip, tail, cut, typed, result
    packet_rows = '{
      '{TYPE_RESPONSE, COOKIE_WORD, NoAttr, 16'h0, NoAttr, 16'h0, 32'h0, 0, 1, 1'b1, R_SHORT},
      '{TYPE_RESPONSE, COOKIE_WORD, NoAttr, 16'h0, NoAttr, 16'h0, 32'h0, 0, 19, 1'b1, R_SHORT},
      '{TYPE_RESPONSE, 32'h2112A443, NoAttr, 16'h0, NoAttr, 16'h0, 32'h0, 0, 12, 1'b1, R_SHORT},
      '{TYPE_RESPONSE, COOKIE_WORD, NoAttr, 16'h0, NoAttr, 16'h0, 32'h0, 0, 0, 1'b1, R_NOADDR},
      '{TYPE_RESPONSE, 32'h2112A443, NoAttr, 16'h0, NoAttr, 16'h0, 32'h0, 0, 0, 1'b1, R_COOKIE},
      '{16'h0001, COOKIE_WORD, NoAttr, 16'h0, NoAttr, 16'h0, 32'h0, 0, 0, 1'b1, R_TYPE},
      '{16'h0100, 32'hFFFFFFFF, NoAttr, 16'h0, 8, 16'h1, 32'h1, 0, 0, 1'b1, R_COOKIE},
      '{16'hFFFF, COOKIE_WORD, NoAttr, 16'h0, 8, 16'h1, 32'h1, 0, 0, 1'b1, R_TYPE},
      '{TYPE_RESPONSE, COOKIE_WORD, NoAttr, 16'h0, 8, 16'hFFFF, 32'hFFFFFFFF, 0, 0, 1'b1,
        R_ONES},
      '{TYPE_RESPONSE, COOKIE_WORD, NoAttr, 16'h0, 8, 16'h0, 32'h0, 0, 0, 1'b1, R_ZERO},
      '{TYPE_RESPONSE, COOKIE_WORD, NoAttr, 16'h0, 4, 16'h1234, 32'h5678, 0, 0, 1'b1, R_ZERO},
      '{TYPE_RESPONSE, COOKIE_WORD, NoAttr, 16'h0, 0, 16'h1234, 32'h5678, 0, 0, 1'b1, R_ZERO},
      '{TYPE_RESPONSE, COOKIE_WORD, NoAttr, 16'h0, 7, 16'h1234, 32'h5678, 0, 0, 1'b1, R_ZERO},
      '{TYPE_RESPONSE, COOKIE_WORD, 5, 16'h0001, 8, 16'd3478, 32'hC0A80001, 0, 0, 1'b0,
        R_NOADDR},
      '{TYPE_RESPONSE, COOKIE_WORD, 0, 16'h8020, 8, 16'h8000, 32'h7F000001, 0, 0, 1'b0,
        R_NOADDR},
      '{TYPE_RESPONSE, COOKIE_WORD, NoAttr, 16'h0, 8, 16'h4321, 32'h1, 0, 29, 1'b1, R_TRUNC},
      '{TYPE_RESPONSE, COOKIE_WORD, NoAttr, 16'h0, 8, 16'h4321, 32'h1, 0, 22, 1'b1, R_NOADDR},
      '{TYPE_RESPONSE, COOKIE_WORD, 12, 16'h0022, 8, 16'h4321, 32'h1, 0, 30, 1'b1, R_NOADDR},
      '{TYPE_RESPONSE, COOKIE_WORD, 3, 16'h8022, 8, 16'h4321, 32'h1, 0, 27, 1'b1, R_NOADDR},
      '{TYPE_RESPONSE, COOKIE_WORD, NoAttr, 16'h0, 12, 16'h1F90, 32'h0A000002, 10, 0, 1'b0,
        R_NOADDR},
      '{TYPE_RESPONSE, COOKIE_WORD, 2, 16'h0020 ^ 16'h0100, 8, 16'h0001, 32'h80000000, 3, 0,
        1'b0, R_NOADDR}
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed packets: header errors, cut points, short values, skipped attributes.
    foreach (packet_rows[r]) begin
      row = packet_rows[r];
      start_packet(row.msg_code, row.cookie);
      if (row.skip_len != NoAttr) add_skip(row.skip_type, row.skip_len);
      if (row.addr_len != NoAttr) add_address(row.addr_len, row.port, row.ip);
      add_noise(row.tail);
      cut_packet(row.cut);
      send_packet(row.typed, row.res);
    end

    // Random packets: mostly well-formed responses, the rest broken or noise.
    while (rand_bytes < RandomBytes || rand_pkts < RandomPackets) begin
      tx_calm = (rand_pkts >= 1 && rand_pkts < 7);
      if (rand_pkts == 8) begin
        byte_ch.valid <= 1'b0;
        wait (results_done == pkts_sent);
        @(posedge clk_i);
      end
      kind     = $urandom_range(99);
      msg_code = TYPE_RESPONSE;
      cookie   = COOKIE_WORD;
      if (kind >= 85 && kind < 93) begin
        if ($urandom_range(1)) msg_code = msg_code ^ (16'h1 << $urandom_range(15));
        else cookie = cookie ^ (32'h1 << $urandom_range(31));
      end
      if (kind < 93) begin
        start_packet(msg_code, cookie);
        repeat ($urandom_range(2)) begin
          attr = 16'($urandom);
          if (attr == ATTR_XOR_MAPPED) attr = attr ^ 16'h0001;
          add_skip(attr, $urandom_range(7));
        end
        add_address(($urandom_range(9) < 8) ? 8 : $urandom_range(12), 16'($urandom),
                    $urandom);
        if ($urandom_range(3) == 0) add_noise($urandom_range(1, 4));
        if (kind >= 75 && kind < 85) cut_packet($urandom_range(1, pkt_bytes.size()));
      end else begin
        pkt_bytes.delete();
        add_noise($urandom_range(1, 40));
      end
      rand_bytes += pkt_bytes.size();
      rand_pkts++;
      send_packet(1'b0, R_NOADDR);
    end
    tx_calm = 1'b0;
    byte_ch.valid <= 1'b0;

    // Drain the remaining results, then let the pipeline settle.
    wait (results_done == pkts_sent);
    repeat (8) @(posedge clk_i);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived",
                                expected_results.size()));

    $display("Run covered %0d packets (%0d directed, %0d random) in %0d bytes.",
             pkts_sent, NumRows, rand_pkts, bytes_sent);
    $display("Header errors, cut points, short values, a sender pause and %s",
             "result back-pressure were exercised.");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Result sink: random stalls, one long hold-off and a stretch without stalls.
  initial begin : result_sink
    int hold_left;
    bit held;
    hold_left = 0;
    held      = 1'b0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held && results_done >= 6) begin
        held      = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (!(results_done >= 14 && results_done < 26) &&
                   $urandom_range(99) < 18) begin
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Scoreboard: predicts on accepted bytes and checks accepted results in order.
  always @(posedge clk_i) begin : scoreboard
    result_t    predicted;
    result_t    want;
    row_check_t note;
    if (rst_ni && byte_ch.valid && byte_ch.ready) begin
      if (advance_parser(byte_ch.rx_byte, byte_ch.last_byte, predicted)) begin
        note = row_results.pop_front();
        expected_results.push_back(note.typed ? note.res : predicted);
      end
    end
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      results_done++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with none expected", results_done));
      end else begin
        want = expected_results.pop_front();
        if (result_ch.found !== want.found)
          report_mismatch($sformatf("result %0d found %0b, expected %0b", results_done,
                                    result_ch.found, want.found));
        if (result_ch.status !== want.status)
          report_mismatch($sformatf("result %0d status %0d, expected %0d", results_done,
                                    result_ch.status, want.status));
        if (result_ch.mapped_ip !== want.mapped_ip)
          report_mismatch($sformatf("result %0d ip %h, expected %h", results_done,
                                    result_ch.mapped_ip, want.mapped_ip));
        if (result_ch.mapped_port !== want.mapped_port)
          report_mismatch($sformatf("result %0d port %h, expected %h", results_done,
                                    result_ch.mapped_port, want.mapped_port));
      end
    end
  end

  // Watchdog: ends the run when no transaction is accepted for too long.
  always @(posedge clk_i) begin
    if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
design/smap_pkg.sv
design/smap_if.sv
design/smap_parser.sv
design/stun_mapped_address_parser_top.sv
tb/sv/stun_mapped_address_parser_top_test.sv
